### rtl/h264_avc_to_annexb_converter_unit_defines.svh
// assertion helpers shared by the converter rtl
`ifndef H264_AVC_TO_ANNEXB_CONVERTER_UNIT_DEFINES_SVH
`define H264_AVC_TO_ANNEXB_CONVERTER_UNIT_DEFINES_SVH

// checked on every rising edge outside reset
`define AVC2AB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define AVC2AB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/avc2ab_pkg.sv
`default_nettype none

package avc2ab_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned LenW  = 23;

  // one queued piece of work for the output side
  typedef struct packed {
    logic             start_code;
    logic [DataW-1:0] data;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/avc2ab_front.sv
`default_nettype none

`include "h264_avc_to_annexb_converter_unit_defines.svh"

module avc2ab_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_wr_en_i,
  input  wire logic                        cfg_wr_data_i,
  input  wire logic                        in_accept_i,
  input  wire logic [avc2ab_pkg::DataW-1:0] data_byte_i,
  input  wire logic                        frame_start_i,
  input  wire logic [avc2ab_pkg::LenW-1:0]  frame_length_i,
  output logic                             cmd_push_o,
  output avc2ab_pkg::cmd_t                 cmd_o
);
  import avc2ab_pkg::*;

  localparam logic [2:0] PhIdle  = 3'd0;
  localparam logic [2:0] PhSkip  = 3'd1;
  localparam logic [2:0] PhCount = 3'd2;
  localparam logic [2:0] PhLen   = 3'd3;
  localparam logic [2:0] PhBody  = 3'd4;

  localparam logic [24:0]     MaxFrameBytes = 25'd4194304;
  localparam logic [LenW-1:0] AvccMinLen    = 23'd7;
  localparam logic [LenW-1:0] AvccCountPos  = 23'd5;
  localparam logic [7:0]      SpsCountMask  = 8'h1f;
  localparam logic [2:0]      AvccLenBytes  = 3'd2;
  localparam logic [2:0]      AuLenBytes    = 3'd4;

  logic            format_mode_q;
  logic            fmode_q, fmode_d;
  logic [2:0]      phase_q, phase_d;
  logic [LenW-1:0] pos_q, pos_d;
  logic [LenW-1:0] total_q, total_d;
  logic [31:0]     acc_q, acc_d;
  logic [1:0]      seen_q, seen_d;
  logic [LenW-1:0] body_rem_q, body_rem_d;
  logic [7:0]      sets_q, sets_d;
  logic            pps_q, pps_d;
  logic            stopped_q, stopped_d;

  logic [2:0]  seen_inc;
  logic [31:0] len_val;
  logic [32:0] end_pos;
  logic        done;

  // where to go once an entry has been fully written out
  function automatic logic [2:0] after_phase(input logic fm, input logic [7:0] sets,
                                             input logic pps, input logic [2:0] ph);
    if (!fm || sets != 8'd0) begin
      return PhLen;
    end else if (pps) begin
      return ph;
    end else begin
      return PhCount;
    end
  endfunction

  always_comb begin
    fmode_d    = fmode_q;
    phase_d    = phase_q;
    pos_d      = pos_q;
    total_d    = total_q;
    acc_d      = acc_q;
    seen_d     = seen_q;
    body_rem_d = body_rem_q;
    sets_d     = sets_q;
    pps_d      = pps_q;
    stopped_d  = stopped_q;
    seen_inc   = '0;
    len_val    = '0;
    end_pos    = '0;
    done       = 1'b0;
    cmd_push_o       = 1'b0;
    cmd_o.start_code = 1'b0;
    cmd_o.data       = data_byte_i;

    if (in_accept_i) begin
      if (frame_start_i) begin
        total_d    = frame_length_i;
        fmode_d    = format_mode_q;
        pos_d      = '0;
        acc_d      = '0;
        seen_d     = '0;
        body_rem_d = '0;
        sets_d     = '0;
        pps_d      = 1'b0;
        stopped_d  = 1'b0;
        phase_d    = format_mode_q ? PhSkip : PhLen;
        if (frame_length_i == '0) begin
          phase_d = PhIdle;
          done    = 1'b1;
        end
        if ({2'b00, frame_length_i} > MaxFrameBytes) begin
          stopped_d = 1'b1;
        end
        if (format_mode_q && frame_length_i < AvccMinLen) begin
          stopped_d = 1'b1;
        end
      end

      if (!done && phase_d != PhIdle) begin
        if (pos_d >= total_d) begin
          phase_d = PhIdle;
        end else begin
          if (!stopped_d) begin
            unique case (phase_d)
              PhSkip: begin
                if (pos_d == AvccCountPos) begin
                  sets_d  = data_byte_i & SpsCountMask;
                  pps_d   = 1'b0;
                  phase_d = (sets_d != 8'd0) ? PhLen : PhCount;
                end
              end
              PhCount: begin
                sets_d = data_byte_i;
                pps_d  = 1'b1;
                if (sets_d == 8'd0) begin
                  stopped_d = 1'b1;
                end else begin
                  phase_d = PhLen;
                end
              end
              PhLen: begin
                acc_d    = {acc_d[23:0], data_byte_i};
                seen_inc = {1'b0, seen_d} + 3'd1;
                if (seen_inc >= (fmode_d ? AvccLenBytes : AuLenBytes)) begin
                  len_val = fmode_d ? {16'd0, acc_d[15:0]} : acc_d;
                  end_pos = {10'd0, pos_d} + 33'd1 + {1'b0, len_val};
                  seen_d  = '0;
                  acc_d   = '0;
                  if (!fmode_d && len_val[31]) begin
                    stopped_d = 1'b1;
                  end else if (end_pos > {10'd0, total_d}) begin
                    // an overrunning sps ends the sps section, anything else stops
                    if (fmode_d && !pps_d) begin
                      phase_d = PhCount;
                    end else begin
                      stopped_d = 1'b1;
                    end
                  end else begin
                    cmd_push_o       = 1'b1;
                    cmd_o.start_code = 1'b1;
                    if (fmode_d && sets_d != 8'd0) begin
                      sets_d = sets_d - 8'd1;
                    end
                    if (len_val != 32'd0) begin
                      body_rem_d = len_val[LenW-1:0];
                      phase_d    = PhBody;
                    end else begin
                      stopped_d = stopped_d | (fmode_d && sets_d == 8'd0 && pps_d);
                      phase_d   = after_phase(fmode_d, sets_d, pps_d, phase_d);
                    end
                  end
                end else begin
                  seen_d = seen_inc[1:0];
                end
              end
              PhBody: begin
                cmd_push_o = 1'b1;
                if (body_rem_d != '0) begin
                  body_rem_d = body_rem_d - 1'b1;
                end
                if (body_rem_d == '0) begin
                  stopped_d = stopped_d | (fmode_d && sets_d == 8'd0 && pps_d);
                  phase_d   = after_phase(fmode_d, sets_d, pps_d, phase_d);
                end
              end
              default: begin
                stopped_d = 1'b1;
              end
            endcase
          end
          pos_d = pos_d + 1'b1;
          if (pos_d >= total_d) begin
            phase_d = PhIdle;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_mode_q <= 1'b0;
      fmode_q       <= 1'b0;
      phase_q       <= PhIdle;
      pos_q         <= '0;
      total_q       <= '0;
      acc_q         <= '0;
      seen_q        <= '0;
      body_rem_q    <= '0;
      sets_q        <= '0;
      pps_q         <= 1'b0;
      stopped_q     <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        format_mode_q <= cfg_wr_data_i;
      end
      fmode_q    <= fmode_d;
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      total_q    <= total_d;
      acc_q      <= acc_d;
      seen_q     <= seen_d;
      body_rem_q <= body_rem_d;
      sets_q     <= sets_d;
      pps_q      <= pps_d;
      stopped_q  <= stopped_d;
    end
  end

  `AVC2AB_ASSERT(a_fe_push_on_accept, cmd_push_o |-> in_accept_i, "work queued without an item")
  `AVC2AB_ASSERT(a_fe_pos_in_frame, (phase_q != PhIdle) |-> (pos_q < total_q), "parser past frame end")
  `AVC2AB_ASSERT(a_fe_body_left, (phase_q == PhBody && !stopped_q) |-> (body_rem_q != '0), "body phase with nothing left")

endmodule

`default_nettype wire

### rtl/avc2ab_queue.sv
`default_nettype none

`include "h264_avc_to_annexb_converter_unit_defines.svh"

module avc2ab_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire avc2ab_pkg::cmd_t  push_data_i,
  output logic                   full_o,
  output logic                   valid_o,
  output avc2ab_pkg::cmd_t       data_o,
  input  wire logic              pop_i
);
  import avc2ab_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `AVC2AB_ASSERT(a_q_no_overflow, push_i |-> !full_o, "push into full queue")
  `AVC2AB_ASSERT(a_q_no_underflow, pop_i |-> valid_o, "pop from empty queue")
  `AVC2AB_ASSERT(a_q_count_up, (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1), "fill count off")
  `AVC2AB_ASSERT_ALWAYS(a_q_count_max, count_q <= CntFull, "fill count beyond depth")

endmodule

`default_nettype wire

### rtl/avc2ab_back.sv
`default_nettype none

`include "h264_avc_to_annexb_converter_unit_defines.svh"

module avc2ab_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         q_valid_i,
  input  wire avc2ab_pkg::cmd_t             q_data_i,
  output logic                              q_pop_o,
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  output logic [avc2ab_pkg::DataW-1:0]      m_axis_tdata_o,
  output logic                              m_axis_tlast_o
);
  import avc2ab_pkg::*;

  localparam logic [1:0]       ScLastIdx = 2'd3;
  localparam logic [DataW-1:0] ScZero    = 8'h00;
  localparam logic [DataW-1:0] ScOne     = 8'h01;

  cmd_t       cur_q, cur_d;
  logic       cur_valid_q, cur_valid_d;
  logic [1:0] cnt_q, cnt_d;
  logic       take;
  logic       finish;

  assign take   = cur_valid_q && m_axis_tready_i;
  assign finish = take && (!cur_q.start_code || cnt_q == ScLastIdx);
  assign q_pop_o = q_valid_i && (!cur_valid_q || finish);

  assign m_axis_tvalid_o = cur_valid_q;
  assign m_axis_tlast_o  = !cur_q.start_code || cnt_q == ScLastIdx;
  assign m_axis_tdata_o  = !cur_q.start_code ? cur_q.data :
                           (cnt_q == ScLastIdx) ? ScOne : ScZero;

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    cnt_d       = cnt_q;
    if (q_pop_o) begin
      cur_d       = q_data_i;
      cur_valid_d = 1'b1;
      cnt_d       = '0;
    end else if (finish) begin
      cur_valid_d = 1'b0;
      cnt_d       = '0;
    end else if (take) begin
      // next byte of the start code
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  `AVC2AB_ASSERT(a_be_pop_has_data, q_pop_o |-> q_valid_i, "pop with queue empty")
  `AVC2AB_ASSERT(a_be_cnt_in_sc, (cnt_q != '0) |-> (cur_valid_q && cur_q.start_code), "count outside start code")
  `AVC2AB_ASSERT(a_be_sc_steps, (take && cur_q.start_code && cnt_q != ScLastIdx) |=> (cur_valid_q && cnt_q == $past(cnt_q) + 1'b1), "start code skipped a byte")

endmodule

`default_nettype wire

### rtl/h264_avc_to_annexb_converter_unit.sv
`default_nettype none

// Converts H.264 frames in length-prefixed form (format_mode 0) or avcC records
// (format_mode 1) into an Annex B byte stream, one source byte per input item with
// frame_start and frame_length riding on the first byte of each frame. The parser
// takes one byte every cycle while the queue has room and hands a body byte or a
// start code to a queue of QUEUE_DEPTH entries; the output side sends a body byte as
// one item and a start code 00 00 00 01 as four bytes, with tlast on each body byte
// and on the final start-code byte. Input rate is one byte per cycle as long as the
// queue has room. In length-prefixed mode the four length bytes cover the four
// start-code bytes, but with the default four-entry queue the body bytes queued
// behind a start code fill it, so a NAL unit of four or more body bytes holds the
// input. In avcC mode each entry has only two length bytes for its four start-code
// bytes, so the output side falls behind at each entry and the input follows it.
// format_mode is latched at each frame start; the user must write it only while
// the block is idle, which the block itself does not enforce.
module h264_avc_to_annexb_converter_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_wr_en_i,
  input  wire logic        cfg_wr_data_i,   // format_mode
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,  // [7:0] data_byte, [30:8] frame_length
  input  wire logic        s_axis_tuser_i,  // frame_start
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,  // [7:0] out_byte
  output logic             m_axis_tlast_o   // run_last
);
  import avc2ab_pkg::*;

  logic in_accept;
  logic push;
  cmd_t push_data;
  logic q_full;
  logic q_valid;
  cmd_t q_data;
  logic q_pop;

  assign s_axis_tready_o = !q_full;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  avc2ab_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_wr_data_i  (cfg_wr_data_i),
    .in_accept_i    (in_accept),
    .data_byte_i    (s_axis_tdata_i[7:0]),
    .frame_start_i  (s_axis_tuser_i),
    .frame_length_i (s_axis_tdata_i[30:8]),
    .cmd_push_o     (push),
    .cmd_o          (push_data)
  );

  avc2ab_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .pop_i       (q_pop)
  );

  avc2ab_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_data_i        (q_data),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

### verif/avc2ab_annexb_checker.sv
`timescale 1ns / 1ps

module avc2ab_annexb_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_wr_en_i,
  input  logic                          cfg_wr_data_i,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [31:0]                   s_tdata_i,
  input  logic                          s_tuser_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [avc2ab_pkg::DataW-1:0]  m_tdata_i,
  input  logic                          m_tlast_i,
  output int unsigned                   pending_o,
  output int unsigned                   mismatches_o
);

  localparam int unsigned MaxFrameBytes = 4194304;
  localparam int unsigned LenW = avc2ab_pkg::LenW;
  localparam int unsigned DataW = avc2ab_pkg::DataW;

  typedef enum logic [2:0] {PhIdle, PhSkip, PhCount, PhLen, PhBody} parse_phase_e;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic             last;
  } annexb_byte_t;

  annexb_byte_t annexb_q[$];

  logic             mode_reg;
  logic             frame_avcc;
  logic             in_pps;
  logic             halted;
  parse_phase_e     phase;
  logic [LenW-1:0]  pos;
  logic [LenW-1:0]  flen;
  logic [LenW-1:0]  body_left;
  logic [31:0]      len_acc;
  logic [7:0]       sets_left;
  int unsigned      len_seen;
  int unsigned      mismatch_count;

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // where parsing goes once an entry's body is done
  task automatic next_entry();
    if (!frame_avcc || sets_left != 0) begin
      phase = PhLen;
    end else if (in_pps) begin
      halted = 1'b1;
    end else begin
      phase = PhCount;
    end
  endtask

  task automatic convert_byte(input logic [DataW-1:0] b, input logic first,
                              input logic [LenW-1:0] len_in);
    logic [31:0] nal_len;
    logic [63:0] reach;
    if (first) begin
      flen       = len_in;
      frame_avcc = mode_reg;
      pos        = '0;
      len_acc    = '0;
      len_seen   = 0;
      body_left  = '0;
      sets_left  = '0;
      in_pps     = 1'b0;
      halted     = 1'b0;
      phase      = frame_avcc ? PhSkip : PhLen;
      if (flen == 0) begin
        phase = PhIdle;
        return;
      end
      if (flen > MaxFrameBytes) halted = 1'b1;
      if (frame_avcc && flen < 7) halted = 1'b1;
    end

    if (phase == PhIdle) return;
    if (pos >= flen) begin
      phase = PhIdle;
      return;
    end

    if (!halted) begin
      case (phase)
        PhSkip: begin
          if (pos == 5) begin
            sets_left = {3'b000, b[4:0]};
            in_pps    = 1'b0;
            phase     = (sets_left != 0) ? PhLen : PhCount;
          end
        end
        PhCount: begin
          sets_left = b;
          in_pps    = 1'b1;
          if (sets_left == 0) halted = 1'b1;
          else phase = PhLen;
        end
        PhLen: begin
          len_acc = {len_acc[23:0], b};
          len_seen++;
          if (len_seen >= (frame_avcc ? 2 : 4)) begin
            nal_len  = frame_avcc ? {16'h0000, len_acc[15:0]} : len_acc;
            len_seen = 0;
            len_acc  = '0;
            reach    = 64'(pos) + 64'd1 + 64'(nal_len);
            if (!frame_avcc && nal_len[31]) begin
              halted = 1'b1;
            end else if (reach > 64'(flen)) begin
              // an sps that overruns closes the sps section instead of stopping
              if (frame_avcc && !in_pps) phase = PhCount;
              else halted = 1'b1;
            end else begin
              annexb_q.push_back({8'h00, 1'b0});
              annexb_q.push_back({8'h00, 1'b0});
              annexb_q.push_back({8'h00, 1'b0});
              annexb_q.push_back({8'h01, 1'b1});
              if (frame_avcc && sets_left != 0) sets_left--;
              if (nal_len != 0) begin
                body_left = nal_len[LenW-1:0];
                phase     = PhBody;
              end else begin
                next_entry();
              end
            end
          end
        end
        PhBody: begin
          annexb_q.push_back({b, 1'b1});
          if (body_left != 0) body_left--;
          if (body_left == 0) next_entry();
        end
        default: begin
          halted = 1'b1;
        end
      endcase
    end

    pos = pos + 1'b1;
    if (pos >= flen) phase = PhIdle;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    annexb_byte_t want;
    if (!rst_ni) begin
      annexb_q.delete();
      mode_reg       = 1'b0;
      frame_avcc     = 1'b0;
      in_pps         = 1'b0;
      halted         = 1'b0;
      phase          = PhIdle;
      pos            = '0;
      flen           = '0;
      body_left      = '0;
      len_acc        = '0;
      sets_left      = '0;
      len_seen       = 0;
      mismatch_count = 0;
    end else begin
      if (cfg_wr_en_i) mode_reg = cfg_wr_data_i;
      if (s_tvalid_i && s_tready_i) begin
        convert_byte(s_tdata_i[DataW-1:0], s_tuser_i, s_tdata_i[LenW+7:8]);
      end
      if (m_tvalid_i && m_tready_i) begin
        if (annexb_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected item %02h last %0b", m_tdata_i, m_tlast_i));
        end else begin
          want = annexb_q.pop_front();
          if (m_tdata_i !== want.data) begin
            flag_mismatch($sformatf("out_byte %02h, want %02h", m_tdata_i, want.data));
          end
          if (m_tlast_i !== want.last) begin
            flag_mismatch($sformatf("run_last %0b, want %0b", m_tlast_i, want.last));
          end
        end
      end
    end
    pending_o    <= annexb_q.size();
    mismatches_o <= mismatch_count;
  end

endmodule

### verif/tb_h264_avc_to_annexb_converter_unit.sv
`timescale 1ns / 1ps

module tb_h264_avc_to_annexb_converter_unit;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxFrameBytes = 4194304;
  localparam int unsigned ItemTarget = 380;
  localparam int unsigned LongHoldCycles = 150;
  localparam logic ModeLengthPrefixed = 1'b0;
  localparam logic ModeAvcc = 1'b1;

  typedef enum int unsigned {
    FrClean, FrTruncate, FrCorrupt, FrBadLength, FrOverrun, FrOpen, FrOddLength
  } flaw_e;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [7:0] data_byte, [30:8] frame_length
  logic        s_axis_tuser;   // frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] out_byte
  logic        m_axis_tlast;   // run_last

  int unsigned pending;
  int unsigned mismatches;
  logic [7:0]  frame_bytes[$];
  int unsigned frame_items;
  bit          quiet;
  bit          tx_noisy;
  bit          hold_off_req;

  h264_avc_to_annexb_converter_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_wr_en_i     (cfg_wr_en),
    .cfg_wr_data_i   (cfg_wr_data),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  avc2ab_annexb_checker annexb_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_wr_en_i   (cfg_wr_en),
    .cfg_wr_data_i (cfg_wr_data),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .m_tlast_i     (m_axis_tlast),
    .pending_o     (pending),
    .mismatches_o  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic push_item(input logic [7:0] data, input logic first,
                           input logic [22:0] flen);
    if (!quiet && tx_noisy && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, flen, data};
    s_axis_tuser  <= first;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
  endtask

  // frame_length rides on the first item only, the rest carry noise there
  task automatic send_frame(input logic [22:0] flen);
    if (frame_bytes.size() == 0) frame_bytes.push_back(8'($urandom));
    foreach (frame_bytes[i]) begin
      push_item(frame_bytes[i], i == 0, (i == 0) ? flen : 23'($urandom));
      frame_items++;
    end
  endtask

  task automatic add_entry(input int unsigned body_len, input logic four_byte,
                           input logic [31:0] extra);
    logic [31:0] declared;
    declared = body_len + extra;
    if (four_byte) begin
      frame_bytes.push_back(declared[31:24]);
      frame_bytes.push_back(declared[23:16]);
    end
    frame_bytes.push_back(declared[15:8]);
    frame_bytes.push_back(declared[7:0]);
    repeat (body_len) frame_bytes.push_back(8'($urandom));
  endtask

  task automatic set_mode(input logic new_mode);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= new_mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic wait_drained(input int unsigned settle);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // receiver: short random stalls, calm stretches and one long hold-off
  initial begin : receiver
    int unsigned hold;
    bit          calm;
    hold = 0;
    calm = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = LongHoldCycles;
      end
      if ($urandom_range(0, 63) == 0) calm = !calm;
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 7);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned size;
    int unsigned n_sps;
    int unsigned n_pps;
    int unsigned nal_count;
    int unsigned r;
    logic [22:0] flen;
    logic [31:0] extra;
    logic [31:0] sps_extra;
    logic [31:0] pps_extra;
    logic        mode;
    flaw_e       flaw;
    bit          stall_done;

    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    frame_items   = 0;
    quiet         = 1'b0;
    tx_noisy      = 1'b1;
    hold_off_req  = 1'b0;
    stall_done    = 1'b0;
    mode          = ModeAvcc;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // length-prefixed corner cases
    set_mode(ModeLengthPrefixed);
    push_item(8'h5a, 1'b0, 23'($urandom));
    frame_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hff};
    send_frame(23'd9);
    frame_bytes = '{8'h00};
    send_frame(23'd0);
    frame_bytes = '{8'h00};
    send_frame(23'h7f_ffff);
    frame_bytes = '{8'h80, 8'h00, 8'h00, 8'h00};
    send_frame(23'd4);
    wait_drained(16);

    // avcC: record too short, then empty sps and pps sections
    set_mode(ModeAvcc);
    frame_bytes = '{8'hff};
    send_frame(23'd6);
    frame_bytes = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'he0, 8'h00};
    send_frame(23'd7);

    while (frame_items < ItemTarget) begin
      mode = !mode;
      wait_drained(16);
      set_mode(mode);
      repeat ($urandom_range(3, 8)) begin
        if (frame_items >= ItemTarget) break;
        if (!stall_done && frame_items >= 150) begin
          hold_off_req = 1'b1;
          stall_done   = 1'b1;
        end
        quiet    = (frame_items >= 320);
        tx_noisy = ($urandom_range(0, 2) != 0);
        r        = $urandom_range(0, 11);
        flaw     = (r < 6) ? FrClean : flaw_e'(r - 5);
        frame_bytes.delete();
        if (mode == ModeAvcc) begin
          n_sps     = $urandom_range(0, 3);
          n_pps     = $urandom_range(0, 3);
          sps_extra = '0;
          pps_extra = '0;
          if (flaw == FrOverrun) begin
            n_sps     = $urandom_range(1, 3);
            sps_extra = 32'h100;
          end
          if (flaw == FrBadLength) begin
            n_pps     = $urandom_range(1, 3);
            pps_extra = 32'h100;
          end
          repeat (5) frame_bytes.push_back(8'($urandom));
          frame_bytes.push_back({3'($urandom), 5'(n_sps)});
          for (int i = 0; i < n_sps; i++) begin
            add_entry($urandom_range(0, 10), 1'b0, (i == 0) ? sps_extra : 32'd0);
          end
          frame_bytes.push_back(8'(n_pps));
          for (int i = 0; i < n_pps; i++) begin
            add_entry($urandom_range(0, 10), 1'b0, (i == 0) ? pps_extra : 32'd0);
          end
        end else begin
          extra = '0;
          if (flaw == FrBadLength) extra = 32'h8000_0000 | 32'($urandom);
          if (flaw == FrOverrun) extra = $urandom_range(1, 300);
          nal_count = $urandom_range(1, 4);
          for (int i = 0; i < nal_count; i++) begin
            add_entry($urandom_range(0, 12), 1'b1, (i == 0) ? extra : 32'd0);
          end
        end
        size = frame_bytes.size();
        flen = 23'(size);
        case (flaw)
          FrTruncate: flen = 23'($urandom_range(1, size - 1));
          FrCorrupt:  frame_bytes[$urandom_range(0, size - 1)] = 8'($urandom);
          FrOpen:     flen = 23'(size + $urandom_range(1, 20));
          FrOddLength: begin
            // empty, short, oversized or maximal frames; open ones get abandoned
            case ($urandom_range(0, 2))
              0:       flen = (mode == ModeAvcc) ? 23'($urandom_range(0, 6)) : 23'd0;
              1:       flen = 23'($urandom_range(MaxFrameBytes + 1, 23'h7f_ffff));
              default: flen = 23'(MaxFrameBytes);
            endcase
          end
          default: ;
        endcase
        send_frame(flen);
      end
    end

    wait_drained(32);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/avc2ab_pkg.sv
rtl/avc2ab_front.sv
rtl/avc2ab_queue.sv
rtl/avc2ab_back.sv
rtl/h264_avc_to_annexb_converter_unit.sv
verif/avc2ab_annexb_checker.sv
verif/tb_h264_avc_to_annexb_converter_unit.sv
